>>> rtl/rfpt_pkg.sv
// rfpt_pkg: shared types and constants for the presence tracker.
// Command/status structs between controller and datapath, frame marker bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfpt_pkg;

    // frame header AA FF 03 00
    localparam logic [7:0] HDR_B0 = 8'hAA;
    localparam logic [7:0] HDR_B1 = 8'hFF;
    localparam logic [7:0] HDR_B2 = 8'h03;
    localparam logic [7:0] HDR_B3 = 8'h00;

    // frame footer FD FC FB FA
    localparam logic [7:0] FTR_B0 = 8'hFD;
    localparam logic [7:0] FTR_B1 = 8'hFC;
    localparam logic [7:0] FTR_B2 = 8'hFB;
    localparam logic [7:0] FTR_B3 = 8'hFA;

    localparam int FTR_LEN       = 4;   // footer bytes
    localparam int MIN_SCAN_FILL = 12;  // shortest frame that is searched
    localparam int WIN_LEN       = 6;   // header + presence + zone
    localparam int WIN_CW        = 3;   // width of window fill counter

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef struct packed {
        logic wr_byte;    // store the accepted byte
        logic cand_pin;   // candidate from pin sample, zone 0
        logic scan_step;  // advance the header search one address
        logic cand_win;   // candidate from the matched window
        logic out_load;   // commit candidate to the output register
    } t_cmd;

    typedef struct packed {
        logic scan_go;    // byte completes a footer on a long enough frame
        logic match;      // window holds a header
        logic scan_done;  // all reads issued and checked
        logic emit_req;   // candidate differs or first result pending
        logic slot_free;  // output register can take a beat
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/rfpt_dp.sv
// rfpt_dp: datapath of the presence tracker.
// Frame store memory, footer detect, sliding-window header search, output register.
// Depends on rfpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfpt_dp
    import rfpt_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_pin_presence,
    input  wire        i_out_ready,
    output logic       o_out_valid,
    output logic       o_person_present,
    output logic [7:0] o_zone_id
);

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int FW = $clog2(FRAME_BYTES + 1);

    logic [7:0]    r_mem [FRAME_BYTES];
    logic [FW-1:0] r_fill;
    logic [7:0]    r_tail [3];     // [0] newest stored byte
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_rd_end;
    logic          r_issue;
    logic          r_rd_vld;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_win [WIN_LEN];
    logic [WIN_CW-1:0] r_win_cnt;
    logic          r_cand_pres;
    logic [7:0]    r_cand_zone;
    logic          r_last;
    logic          r_first;
    logic          r_out_valid;
    logic          r_out_pres;
    logic [7:0]    r_out_zone;

    logic [FW-1:0] w_base;
    logic [FW-1:0] w_fill;
    logic [AW-1:0] w_waddr;
    logic          w_footer;
    logic          w_long;
    logic          w_slot_free;

    // full store wraps to empty before the write
    assign w_base   = (r_fill >= FW'(FRAME_BYTES)) ? '0 : r_fill;
    assign w_waddr  = w_base[AW-1:0];
    assign w_fill   = w_base + FW'(1);
    assign w_footer = (w_fill >= FW'(FTR_LEN)) && (r_tail[2] == FTR_B0) &&
                      (r_tail[1] == FTR_B1) && (r_tail[0] == FTR_B2) &&
                      (i_rx_byte == FTR_B3);
    assign w_long   = (w_fill >= FW'(MIN_SCAN_FILL));
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_stat.scan_go   = w_footer && w_long;
    assign o_stat.match     = (r_win_cnt == WIN_CW'(WIN_LEN)) &&
                              (r_win[0] == HDR_B0) && (r_win[1] == HDR_B1) &&
                              (r_win[2] == HDR_B2) && (r_win[3] == HDR_B3);
    assign o_stat.scan_done = !r_issue && !r_rd_vld;
    assign o_stat.emit_req  = r_first || (r_cand_pres != r_last);
    assign o_stat.slot_free = w_slot_free;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_mem[w_waddr] <= i_rx_byte;
        end
        if (i_cmd.scan_step && r_issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_tail[2] <= r_tail[1];
            r_tail[1] <= r_tail[0];
            r_tail[0] <= i_rx_byte;
            if (w_footer && w_long) begin
                r_rd_end <= AW'(w_fill - FW'(WIN_LEN + 1));
            end
        end
        if (i_cmd.scan_step && r_rd_vld) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_LEN-1] <= r_rd_data;
        end
        if (i_cmd.cand_pin) begin
            r_cand_pres <= i_pin_presence;
            r_cand_zone <= '0;
        end else if (i_cmd.cand_win) begin
            r_cand_pres <= r_win[4][0];
            r_cand_zone <= r_win[5];
        end
        if (i_cmd.out_load) begin
            r_out_pres <= r_cand_pres;
            r_out_zone <= r_cand_zone;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_addr   <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_win_cnt   <= '0;
            r_last      <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_byte) begin
                if (w_footer) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= w_fill;
                end
                if (w_footer && w_long) begin
                    r_rd_addr <= '0;
                    r_issue   <= 1'b1;
                    r_rd_vld  <= 1'b0;
                    r_win_cnt <= '0;
                end
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= r_issue;
                if (r_issue) begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                    if (r_rd_addr == r_rd_end) begin
                        r_issue <= 1'b0;
                    end
                end
                if (r_rd_vld && (r_win_cnt != WIN_CW'(WIN_LEN))) begin
                    r_win_cnt <= r_win_cnt + WIN_CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_last      <= r_cand_pres;
                r_first     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_person_present = r_out_pres;
    assign o_zone_id        = r_out_zone;

endmodule

`default_nettype wire

>>> rtl/rfpt_ctrl.sv
// rfpt_ctrl: controller state machine of the presence tracker.
// Accepts input beats, sequences the header search and result commit.
// Depends on rfpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfpt_ctrl
    import rfpt_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_op,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_beat;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_beat     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_beat) begin
                    if (i_op == OP_TIMEOUT) begin
                        o_cmd.cand_pin = 1'b1;
                        n_state        = ST_DECIDE;
                    end else begin
                        o_cmd.wr_byte = 1'b1;
                        if (i_stat.scan_go) begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.cand_win = 1'b1;
                    n_state        = ST_DECIDE;
                end else if (i_stat.scan_done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (!i_stat.emit_req) begin
                    n_state = ST_IDLE;
                end else if (i_stat.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/radar_frame_presence_tracker_core.sv
// radar_frame_presence_tracker_core: top level of the presence tracker.
// Joins rfpt_ctrl (state machine) and rfpt_dp (store, search, output register).
// Depends on rfpt_pkg, rfpt_ctrl, rfpt_dp.
//
// Usage:
//   Slave channel: one beat is a received serial byte (tuser = 0) or a read
//   timeout carrying the presence pin sample (tuser = 1).
//   Master channel: one beat per presence change (or the first presence after
//   reset): person_present and zone_id (zone 0 when taken from the pin).
// Sequence:
//   An ordinary byte is only stored. A timeout takes the pin sample as candidate
//   and passes it to the commit step. A byte that closes a frame of F bytes
//   (F >= 12) starts a header search that reads the frame store once per address,
//   0..F-7, through its single registered read port; the first match goes to the
//   commit step. Input is held off while the search runs. Shorter frames are not
//   searched.
// Reset (i_rst_n low, synchronous): empties the store, clears the output beat,
//   and arms the first-result flag. Store contents are not cleared; only
//   written positions are ever read.
// Stall: the output register holds one result; input keeps flowing while it
//   waits. A further result waits in the commit step until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module radar_frame_presence_tracker_core
    import rfpt_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [7:0] rx_byte, [8] pin_presence, [15:9] zero
    input  wire         i_s_tuser,   // [0] op: 0 byte, 1 timeout
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [0] person_present, [8:1] zone_id, [15:9] zero
);

    t_cmd       w_cmd;
    t_stat      w_stat;
    logic       w_pres;
    logic [7:0] w_zone;

    rfpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rfpt_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_rx_byte        (i_s_tdata[7:0]),
        .i_pin_presence   (i_s_tdata[8]),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_person_present (w_pres),
        .o_zone_id        (w_zone)
    );

    assign o_m_tdata = {7'd0, w_zone, w_pres};

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking bench for radar_frame_presence_tracker_core.
// Drives byte and timeout beats and tracks presence in a local model.
// Depends on rfpt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
    import rfpt_pkg::*;
();

    localparam int STORE_DEPTH  = 32;
    localparam int ITEM_TARGET  = 1700;
    localparam int GAP_PCT      = 22;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    localparam int DRAIN_CYCLES = 48;
    localparam int IDLE_LIMIT   = 4000;

    localparam logic [31:0] HDR_WORD = {HDR_B3, HDR_B2, HDR_B1, HDR_B0};
    localparam logic [31:0] FTR_WORD = {FTR_B3, FTR_B2, FTR_B1, FTR_B0};

    typedef struct {
        logic       op;
        logic [7:0] rx;
        logic       pin;
        bit         typed;  // expectation given in the row
        bit         hit;
        logic       pres;
        logic [7:0] zone;
    } t_stim_row;

    typedef struct {
        logic       pres;
        logic [7:0] zone;
    } t_presence_rpt;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [15:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tready   = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;

    // local copy of the tracker state
    logic [7:0] frame_img [STORE_DEPTH];
    int         frame_fill = 0;
    logic       last_pres  = 1'b0;
    bit         first_due  = 1'b1;

    t_presence_rpt pending_rpts[$];
    t_stim_row     dir_rows[$];
    int            err_count  = 0;
    int            items_sent = 0;
    bit            calm       = 1'b0;
    int            idle_run   = 0;

    radar_frame_presence_tracker_core #(
        .FRAME_BYTES(STORE_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),     // [7:0] rx_byte, [8] pin_presence, [15:9] zero
        .i_s_tuser (s_tuser),     // [0] op
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata)    // [0] person_present, [8:1] zone_id, [15:9] zero
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Presence tracking: byte append, footer detect, header search, change filter.
    task automatic update_tracker(input logic op, input logic [7:0] rx, input logic pin,
                                  output bit hit, output logic pres,
                                  output logic [7:0] zone);
        bit have;
        bit found;
        int p;
        have  = 1'b0;
        found = 1'b0;
        pres  = 1'b0;
        zone  = 8'h00;
        if (op == OP_TIMEOUT) begin
            pres = pin;
            have = 1'b1;
        end else begin
            if (frame_fill >= STORE_DEPTH)
                frame_fill = 0;   // overflow empties the store
            frame_img[frame_fill] = rx;
            frame_fill++;
            if (frame_fill >= 4 &&
                    {frame_img[frame_fill-1], frame_img[frame_fill-2],
                     frame_img[frame_fill-3], frame_img[frame_fill-4]} == FTR_WORD) begin
                if (frame_fill >= MIN_SCAN_FILL) begin
                    for (p = 0; p <= frame_fill - MIN_SCAN_FILL; p++) begin
                        if (!found && {frame_img[p+3], frame_img[p+2],
                                       frame_img[p+1], frame_img[p]} == HDR_WORD) begin
                            found = 1'b1;
                            pres  = frame_img[p+4][0];
                            zone  = frame_img[p+5];
                        end
                    end
                end
                have       = found;
                frame_fill = 0;
            end
        end
        hit = have && (pres != last_pres || first_due);
        if (hit) begin
            first_due = 1'b0;
            last_pres = pres;
        end
    endtask

    // One input beat: random gap, handshake, then predict.
    task automatic apply_row(input t_stim_row r);
        bit         hit;
        logic       pres;
        logic [7:0] zone;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.pin, r.rx};
        s_tuser  <= r.op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
        calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
        update_tracker(r.op, r.rx, r.pin, hit, pres, zone);
        if (r.typed) begin
            if (hit != r.hit || (hit && (pres !== r.pres || zone !== r.zone)))
                flag_error($sformatf("table row %0d disagrees with tracker", items_sent));
            if (r.hit)
                pending_rpts.push_back('{r.pres, r.zone});
        end else if (hit) begin
            pending_rpts.push_back('{pres, zone});
        end
    endtask

    function automatic t_stim_row make_row(input logic op, input logic [7:0] rx,
                                           input logic pin, input bit typed, input bit hit,
                                           input logic pres, input logic [7:0] zone);
        t_stim_row r;
        r.op    = op;
        r.rx    = rx;
        r.pin   = pin;
        r.typed = typed;
        r.hit   = hit;
        r.pres  = pres;
        r.zone  = zone;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        apply_row(make_row(OP_BYTE, b, 1'($urandom), 1'b0, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(8'($urandom));
    endtask

    // lead junk, header (maybe corrupted), presence, zone, pad junk, footer
    task automatic send_frame(input int lead, input bit hdr_ok, input int pad,
                              input logic [7:0] pres_b, input logic [7:0] zone_b);
        logic [31:0] hdr;
        int i;
        hdr = HDR_WORD;
        if (!hdr_ok)
            hdr[8*$urandom_range(3) +: 8] ^= 8'($urandom_range(255, 1));
        send_noise(lead);
        for (i = 0; i < 4; i++)
            send_byte(hdr[8*i +: 8]);
        send_byte(pres_b);
        send_byte(zone_b);
        send_noise(pad);
        for (i = 0; i < 4; i++)
            send_byte(FTR_WORD[8*i +: 8]);
    endtask

    function automatic logic [7:0] pick_pres();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(99) < 60)
            b[0] = ~last_pres;
        return b;
    endfunction

    function automatic logic [7:0] pick_zone();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // receiver back-pressure
    always @(negedge i_clk)
        m_tready <= calm || ($urandom_range(99) >= GAP_PCT);

    // result check
    always @(posedge i_clk) begin
        t_presence_rpt want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_rpts.size() == 0) begin
                flag_error($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                want = pending_rpts.pop_front();
                if (o_m_tdata[0] !== want.pres)
                    flag_error($sformatf("person_present %b, want %b",
                                         o_m_tdata[0], want.pres));
                if (o_m_tdata[8:1] !== want.zone)
                    flag_error($sformatf("zone_id %h, want %h", o_m_tdata[8:1], want.zone));
                if (o_m_tdata[15:9] !== 7'd0)
                    flag_error($sformatf("pad bits %h not zero", o_m_tdata[15:9]));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= IDLE_LIMIT) begin
                $display("radar_frame_presence_tracker_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int roll;
        // first timeout reports even at level 0; rx ignored on timeout
        dir_rows.push_back(make_row(OP_TIMEOUT, 8'hFF, 1'b0, 1, 1, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_TIMEOUT, 8'h00, 1'b0, 1, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_TIMEOUT, 8'hA5, 1'b1, 1, 1, 1'b1, 8'h00));
        // minimal frame, header at the last searchable slot; pin ignored on bytes
        dir_rows.push_back(make_row(OP_BYTE, HDR_B0, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, HDR_B1, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, HDR_B2, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, HDR_B3, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, 8'hFE, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, 8'h00, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, 8'hFF, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, 8'h00, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B0, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B1, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B2, 1'b1, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B3, 1'b1, 1, 1, 1'b0, 8'h00));
        // bare footer: too short to search, no result
        dir_rows.push_back(make_row(OP_BYTE, FTR_B0, 1'b0, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B1, 1'b0, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B2, 1'b0, 0, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_BYTE, FTR_B3, 1'b0, 1, 0, 1'b0, 8'h00));
        dir_rows.push_back(make_row(OP_TIMEOUT, 8'h5A, 1'b1, 1, 1, 1'b1, 8'h00));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            apply_row(dir_rows[i]);

        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 58) begin
                send_frame($urandom_range(3), 1'b1, $urandom_range(10, 2),
                           pick_pres(), pick_zone());
            end else if (roll < 70) begin
                apply_row(make_row(OP_TIMEOUT, 8'($urandom), 1'($urandom),
                                   1'b0, 1'b0, 1'b0, 8'h00));
            end else if (roll < 77) begin
                send_noise($urandom_range(6, 1));
            end else if (roll < 83) begin
                // header sits past the searched range
                send_frame($urandom_range(8, 2), 1'b1, $urandom_range(1),
                           pick_pres(), pick_zone());
            end else if (roll < 89) begin
                send_frame($urandom_range(3), 1'b0, $urandom_range(8, 2),
                           pick_pres(), pick_zone());
            end else if (roll < 95) begin
                // two headers in one frame: the first decides
                for (i = 0; i < 4; i++)
                    send_byte(HDR_WORD[8*i +: 8]);
                send_byte(pick_pres());
                send_byte(pick_zone());
                send_frame(0, 1'b1, $urandom_range(12, 2), 8'($urandom), 8'($urandom));
            end else begin
                // store overflow, then a frame
                send_noise($urandom_range(40, 33));
                send_frame($urandom_range(3), 1'b1, $urandom_range(10, 2),
                           pick_pres(), pick_zone());
            end
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_rpts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("radar_frame_presence_tracker_core regression: pass");
        else
            $display("radar_frame_presence_tracker_core regression: fail");
        $finish;
    end

endmodule
